### sv/b1d_pkg.sv
package b1d_pkg;

  localparam int SAMPLE_W       = 16;
  localparam int IDX_W          = 8;
  localparam int COEF_W         = 16;
  localparam int CFG_IDX_W      = 1;
  localparam int ROW_LENGTH_DEF = 32;

  localparam logic [COEF_W-1:0] COURANT_RST   = 16'd6226;
  localparam logic [COEF_W-1:0] DIFFUSION_RST = 16'd2957;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COURANT   = 1'b0,
    REG_DIFFUSION = 1'b1
  } b1d_reg_t;

  // one stencil point to update
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left;
    logic signed [SAMPLE_W-1:0] centre;
    logic signed [SAMPLE_W-1:0] right;
    logic [IDX_W-1:0]           index;
    logic                       done;
  } b1d_job_t;

  // one updated point
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] new_sample;
    logic [IDX_W-1:0]           sample_index;
    logic                       saturated;
    logic                       row_done;
  } b1d_result_t;

endpackage

### sv/b1d_in_if.sv
interface b1d_in_if
  import b1d_pkg::*;
  ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       last_sample;

  modport source (output valid, output sample, output last_sample, input ready);
  modport sink   (input valid, input sample, input last_sample, output ready);
endinterface

### sv/b1d_out_if.sv
interface b1d_out_if
  import b1d_pkg::*;
  ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] new_sample;
  logic [IDX_W-1:0]           sample_index;
  logic                       saturated;
  logic                       row_done;

  modport source (output valid, output new_sample, output sample_index,
                  output saturated, output row_done, input ready);
  modport sink   (input valid, input new_sample, input sample_index,
                  input saturated, input row_done, output ready);
endinterface

### sv/burgers_1d_stencil_step.sv
// One explicit time step of the 1D viscous Burgers equation on a periodic row
// of signed Q6.10 samples, one sample per input word. Points 1..N-3 come out as
// the row streams by; the word flagged last_sample (or the word at index
// ROW_LENGTH-1) also yields points N-2, N-1 and finally 0 with row_done set.
// Each result passes through a three-stage multiply pipeline and then the output
// register before it is valid at the output. The next result is started only at
// the edge where the previous one leaves the output register, or while that
// register is empty, and a new sample is accepted only once every point of the
// previous one has been started. The first two samples of a row cause no
// result. Receiver stalls delay the next start.
// Configuration writes are legal only while the block is idle.
module burgers_1d_stencil_step
  import b1d_pkg::*;
#(
  parameter int ROW_LENGTH = ROW_LENGTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COEF_W-1:0]    cfg_data,
  b1d_in_if.sink               in_ch,
  b1d_out_if.source            out_ch
);

  localparam logic [IDX_W-1:0] LAST_POS = IDX_W'(ROW_LENGTH - 1);

  logic [COEF_W-1:0] courant_r, diffusion_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      courant_r   <= COURANT_RST;
      diffusion_r <= DIFFUSION_RST;
    end else if (cfg_we) begin
      if (cfg_index == REG_COURANT) begin
        courant_r <= cfg_data;
      end
      if (cfg_index == REG_DIFFUSION) begin
        diffusion_r <= cfg_data;
      end
    end
  end

  logic                       accept;
  logic [2:0]                 pend_r, pend_nxt;
  b1d_job_t                   job_r [3];
  b1d_job_t                   job_nxt [3];
  logic [IDX_W-1:0]           pos_r;
  logic signed [SAMPLE_W-1:0] first0_r, first1_r;
  logic signed [SAMPLE_W-1:0] win0, win1;
  logic                       row_end;
  b1d_job_t                   job_a, job_b, job_c;
  logic                       has_a, has_b;
  logic                       issue;
  logic                       pipe_busy;
  logic                       res_valid;
  b1d_result_t                res;
  logic                       out_valid_r;
  b1d_result_t                out_r;
  logic                       upd_v1, upd_v2;

  assign accept       = in_ch.valid & in_ch.ready;
  assign in_ch.ready  = ~|pend_r;

  // window cells: the sample shifts into win1, then on to win0
  b1d_cell u_cell_w1 (
    .clk      (clk),
    .rst_n    (rst_n),
    .shift_en (accept),
    .d_in     (in_ch.sample),
    .q        (win1)
  );

  b1d_cell u_cell_w0 (
    .clk      (clk),
    .rst_n    (rst_n),
    .shift_en (accept),
    .d_in     (win1),
    .q        (win0)
  );

  // build the stencil points this word completes
  always_comb begin
    row_end      = in_ch.last_sample | (pos_r >= LAST_POS);
    has_a        = pos_r >= IDX_W'(2);
    has_b        = row_end & (pos_r != '0);

    job_a.left   = win0;
    job_a.centre = win1;
    job_a.right  = in_ch.sample;
    job_a.index  = pos_r - IDX_W'(1);
    job_a.done   = 1'b0;

    job_b.left   = win1;
    job_b.centre = in_ch.sample;
    job_b.right  = first0_r;
    job_b.index  = pos_r;
    job_b.done   = 1'b0;

    job_c.left   = in_ch.sample;
    job_c.centre = (pos_r == '0) ? in_ch.sample : first0_r;
    job_c.right  = (pos_r >= IDX_W'(2)) ? first1_r : in_ch.sample;
    job_c.index  = '0;
    job_c.done   = 1'b1;
  end

  // queue the points in order, or drop the head once it is issued
  always_comb begin
    job_nxt[0] = job_r[0];
    job_nxt[1] = job_r[1];
    job_nxt[2] = job_r[2];
    pend_nxt   = pend_r;
    if (accept) begin
      priority if (has_a && has_b) begin
        job_nxt[0] = job_a;
        job_nxt[1] = job_b;
        job_nxt[2] = job_c;
        pend_nxt   = 3'b111;
      end else if (has_a && row_end) begin
        job_nxt[0] = job_a;
        job_nxt[1] = job_c;
        pend_nxt   = 3'b011;
      end else if (has_a) begin
        job_nxt[0] = job_a;
        pend_nxt   = 3'b001;
      end else if (has_b) begin
        job_nxt[0] = job_b;
        job_nxt[1] = job_c;
        pend_nxt   = 3'b011;
      end else if (row_end) begin
        job_nxt[0] = job_c;
        pend_nxt   = 3'b001;
      end else begin
        pend_nxt   = 3'b000;
      end
    end else if (issue) begin
      job_nxt[0] = job_r[1];
      job_nxt[1] = job_r[2];
      pend_nxt   = {1'b0, pend_r[2:1]};
    end
  end

  always_ff @(posedge clk) begin
    job_r[0] <= job_nxt[0];
    job_r[1] <= job_nxt[1];
    job_r[2] <= job_nxt[2];
  end

  // row position and the first two samples for the wrap
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r   <= '0;
      pos_r    <= '0;
      first0_r <= '0;
      first1_r <= '0;
    end else begin
      pend_r <= pend_nxt;
      if (accept) begin
        pos_r <= row_end ? '0 : pos_r + IDX_W'(1);
        if (pos_r == '0) begin
          first0_r <= in_ch.sample;
        end
        if (pos_r == IDX_W'(1)) begin
          first1_r <= in_ch.sample;
        end
      end
    end
  end

  // one point in flight at a time; start the next as the output frees up
  assign pipe_busy = upd_v1 | upd_v2 | res_valid;
  assign issue     = pend_r[0] & ~pipe_busy & (~out_valid_r | out_ch.ready);

  b1d_update u_update (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (issue),
    .job       (job_r[0]),
    .courant   (courant_r),
    .diffusion (diffusion_r),
    .res_valid (res_valid),
    .res       (res)
  );

  // track the first two pipeline stages for the busy check
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upd_v1 <= 1'b0;
      upd_v2 <= 1'b0;
    end else begin
      upd_v1 <= issue;
      upd_v2 <= upd_v1;
    end
  end

  // output register: hold the word until it is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_r <= res;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.new_sample   = out_r.new_sample;
  assign out_ch.sample_index = out_r.sample_index;
  assign out_ch.saturated    = out_r.saturated;
  assign out_ch.row_done     = out_r.row_done;

endmodule

### sv/b1d_cell.sv
module b1d_cell
  import b1d_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       shift_en,
  input  logic signed [SAMPLE_W-1:0] d_in,
  output logic signed [SAMPLE_W-1:0] q
);

  logic signed [SAMPLE_W-1:0] val_r;

  // take the neighbor's sample on each shift
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_r <= '0;
    end else if (shift_en) begin
      val_r <= d_in;
    end
  end

  assign q = val_r;

endmodule

### sv/b1d_update.sv
module b1d_update
  import b1d_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              job_valid,
  input  b1d_job_t          job,
  input  logic [COEF_W-1:0] courant,
  input  logic [COEF_W-1:0] diffusion,
  output logic              res_valid,
  output b1d_result_t       res
);

  localparam int P1_W  = 2 * SAMPLE_W + 1;
  localparam int PD_W  = SAMPLE_W + 2 + COEF_W + 1;
  localparam int CV_W  = P1_W + COEF_W + 1;
  localparam int TOT_W = CV_W + 2;

  // stage 1: differences and first products
  logic signed [SAMPLE_W:0]   du;
  logic signed [SAMPLE_W+1:0] lap;
  logic signed [P1_W-1:0]     p1_nxt;
  logic signed [PD_W-1:0]     pd_nxt;

  assign du     = {job.centre[SAMPLE_W-1], job.centre} - {job.left[SAMPLE_W-1], job.left};
  assign lap    = {{2{job.right[SAMPLE_W-1]}}, job.right}
                - ({{2{job.centre[SAMPLE_W-1]}}, job.centre} <<< 1)
                + {{2{job.left[SAMPLE_W-1]}}, job.left};
  assign p1_nxt = P1_W'(du * job.centre);
  assign pd_nxt = PD_W'(lap * $signed({1'b0, diffusion}));

  logic                       v1_r, v2_r, v3_r;
  logic signed [P1_W-1:0]     p1_r;
  logic signed [PD_W-1:0]     pd1_r, pd2_r;
  logic signed [SAMPLE_W-1:0] u1_r, u2_r;
  logic [IDX_W-1:0]           idx1_r, idx2_r;
  logic                       done1_r, done2_r;
  logic signed [CV_W-1:0]     conv_r;
  logic signed [CV_W-1:0]     conv_nxt;
  b1d_result_t                res_r, res_nxt;

  // stage 2: convection product times courant factor
  assign conv_nxt = CV_W'(p1_r * $signed({1'b0, courant}));

  // stage 3: sum, round half up, saturate
  logic signed [TOT_W-1:0] total;
  logic signed [TOT_W-1:0] shifted;

  always_comb begin
    total   = (TOT_W'(u2_r) <<< 26) - TOT_W'(conv_r) + (TOT_W'(pd2_r) <<< 10);
    shifted = (total + (TOT_W'(1) <<< 25)) >>> 26;
    res_nxt.sample_index = idx2_r;
    res_nxt.row_done     = done2_r;
    priority if (shifted > TOT_W'(32767)) begin
      res_nxt.new_sample = 16'sh7FFF;
      res_nxt.saturated  = 1'b1;
    end else if (shifted < -TOT_W'(32768)) begin
      res_nxt.new_sample = -16'sh8000;
      res_nxt.saturated  = 1'b1;
    end else begin
      res_nxt.new_sample = shifted[SAMPLE_W-1:0];
      res_nxt.saturated  = 1'b0;
    end
  end

  // advance the valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= job_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // advance the payload
  always_ff @(posedge clk) begin
    p1_r    <= p1_nxt;
    pd1_r   <= pd_nxt;
    u1_r    <= job.centre;
    idx1_r  <= job.index;
    done1_r <= job.done;
    conv_r  <= conv_nxt;
    pd2_r   <= pd1_r;
    u2_r    <= u1_r;
    idx2_r  <= idx1_r;
    done2_r <= done1_r;
    res_r   <= res_nxt;
  end

  assign res_valid = v3_r;
  assign res       = res_r;

endmodule
